// File: hdl/mlf_pkg.sv
// Shared types and constants for the multiplicative lagged Fibonacci generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mlf_pkg;

  localparam int WordW = 64;
  localparam int HalfW = 32;
  localparam int MaxLagDef = 128;

  localparam int ShortLagW = 7;
  localparam int LongLagW = 8;
  localparam int LoadIdxW = 7;

  localparam logic [ShortLagW-1:0] ShortLagRst = 7'd7;
  localparam logic [LongLagW-1:0] LongLagRst = 8'd10;

  localparam logic KindLoad = 1'b0;
  localparam logic KindGen = 1'b1;

  typedef enum logic [0:0] {
    CFG_SHORT_LAG = 1'b0,
    CFG_LONG_LAG  = 1'b1
  } cfg_idx_e;

  // Which 32x32 partial product the shared multiplier forms this cycle.
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_step_e;

  typedef struct packed {
    logic      en;
    mul_step_e step;
  } mul_op_t;

endpackage

// File: hdl/mlf_ring.sv
// Lag ring storage: one write port, two registered read ports, clearing sweep.
// Depends on mlf_pkg.
`timescale 1ns / 1ps

module mlf_ring #(
  parameter int Depth = mlf_pkg::MaxLagDef,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_a_i,
  input  logic [AddrW-1:0]          rd_addr_b_i,
  output logic [mlf_pkg::WordW-1:0] rd_data_a_o,
  output logic [mlf_pkg::WordW-1:0] rd_data_b_o,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [mlf_pkg::WordW-1:0] wr_data_i,
  output logic                      clearing_o
);
  import mlf_pkg::*;

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rd_a_q, rd_b_q;
  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             we;
  logic [AddrW-1:0] wa;
  logic [WordW-1:0] wd;

  // After reset every entry is swept to zero, one per cycle.
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign we = clr_q | wr_en_i;
  assign wa = clr_q ? clr_cnt_q : wr_addr_i;
  assign wd = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
  assign clearing_o  = clr_q;

endmodule

// File: hdl/mlf_mul.sv
// 64x64 multiply modulo 2^64 built from three passes of one 32x32 multiplier.
// Depends on mlf_pkg.
`timescale 1ns / 1ps

module mlf_mul (
  input  logic                      clk_i,
  input  mlf_pkg::mul_op_t          op_i,
  input  logic [mlf_pkg::WordW-1:0] a_i,
  input  logic [mlf_pkg::WordW-1:0] b_i,
  output logic [mlf_pkg::WordW-1:0] result_o
);
  import mlf_pkg::*;

  logic [HalfW-1:0] x, y;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] acc_q, acc_d;

  always_comb begin
    unique case (op_i.step)
      MUL_LL: begin
        x = a_i[HalfW-1:0];
        y = b_i[HalfW-1:0];
      end
      MUL_LH: begin
        x = a_i[HalfW-1:0];
        y = b_i[WordW-1:HalfW];
      end
      MUL_HL: begin
        x = a_i[WordW-1:HalfW];
        y = b_i[HalfW-1:0];
      end
      default: begin
        x = '0;
        y = '0;
      end
    endcase
  end

  assign prod = WordW'(x) * WordW'(y);

  // Cross terms only reach the upper half; their own upper halves fall off.
  always_comb begin
    if (op_i.step == MUL_LL) begin
      acc_d = prod;
    end else begin
      acc_d = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign result_o = acc_d;

endmodule

// File: hdl/multiplicative_lagged_fibonacci.sv
// Top level of the 64-bit multiplicative lagged Fibonacci generator.
// Depends on mlf_pkg, mlf_ring and mlf_mul.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_ready_o   kind_i, load_index_i, load_value_i
//  out      output     out_valid_o/out_ready_i random_value_o, lag_error_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  A load transaction writes the ring in the cycle it is accepted, and the block is
//  ready for the next item in the next cycle. A generate transaction is a ring read,
//  then three passes of the shared 32x32 multiplier; the last pass writes the product
//  back and fills the output register. The passes run one after another on the single multiplier.
//  After reset the ring is swept to zero with in_ready_o low.
//  A full output register stalls the last pass until the result transaction is taken.

module multiplicative_lagged_fibonacci #(
  parameter int MAX_LAG = mlf_pkg::MaxLagDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [mlf_pkg::LoadIdxW-1:0]  load_index_i,
  input  logic [mlf_pkg::WordW-1:0]     load_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mlf_pkg::WordW-1:0]     random_value_o,
  output logic                          lag_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  mlf_pkg::cfg_idx_e             cfg_index_i,
  input  logic [mlf_pkg::LongLagW-1:0]  cfg_data_i
);
  import mlf_pkg::*;

  localparam int PtrW = $clog2(MAX_LAG);
  localparam int LenW = $clog2(MAX_LAG + 1);
  localparam int SumW = LenW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ERR
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [ShortLagW-1:0] short_lag_q;
  logic [LongLagW-1:0]  long_lag_q;

  // Ring pointer and the per-item addresses captured at accept time.
  logic [PtrW-1:0] ptr_q, p_q, nxt_ptr_q;

  // Output register.
  logic             out_valid_q;
  logic [WordW-1:0] random_value_q;
  logic             lag_error_q;

  logic             clearing;
  logic             in_acc, gen_acc, load_acc, slot_free, wb_go;
  logic [LenW-1:0]  len, p_inc;
  logic [PtrW-1:0]  ptr_eff, q_addr, nxt_ptr;
  logic [SumW-1:0]  q_sum, q_wrap;
  logic             lags_ok;
  logic [WordW-1:0] rd_a, rd_b, product;
  logic             wr_en;
  logic [PtrW-1:0]  wr_addr;
  logic [WordW-1:0] wr_data;
  mul_op_t          mul_op;

  assign cfg_ready_o = 1'b1;

  // One item is in flight at a time, so a ring write always lands before the next
  // read and no forwarding path is needed.
  assign in_ready_o = (state_q == S_IDLE) && !clearing;
  assign in_acc     = in_valid_i && in_ready_o;
  assign gen_acc    = in_acc && (kind_i == KindGen);
  assign load_acc   = in_acc && (kind_i == KindLoad) && (int'(load_index_i) < MAX_LAG);
  assign slot_free  = !out_valid_q || out_ready_i;

  // Active ring length saturates at the storage depth.
  assign len = (int'(long_lag_q) >= MAX_LAG) ? LenW'(MAX_LAG) : LenW'(long_lag_q);
  assign lags_ok = (short_lag_q != '0) && (int'(short_lag_q) < int'(len));

  // A pointer left beyond a shrunken ring restarts at zero.
  assign ptr_eff = (int'(ptr_q) >= int'(len)) ? '0 : ptr_q;

  // Short-lag word sits (len - k) places past the oldest word, modulo len.
  assign q_sum  = SumW'(ptr_eff) + SumW'(len) - SumW'(short_lag_q);
  assign q_wrap = (q_sum >= SumW'(len)) ? (q_sum - SumW'(len)) : q_sum;
  assign q_addr = PtrW'(q_wrap);

  assign p_inc   = LenW'(ptr_eff) + LenW'(1);
  assign nxt_ptr = (p_inc == len) ? '0 : PtrW'(p_inc);

  // Multiplier passes follow the sequencer state.
  always_comb begin
    mul_op.en   = 1'b0;
    mul_op.step = MUL_LL;
    unique case (state_q)
      S_MUL0: begin
        mul_op.en   = 1'b1;
        mul_op.step = MUL_LL;
      end
      S_MUL1: begin
        mul_op.en   = 1'b1;
        mul_op.step = MUL_LH;
      end
      S_MUL2: begin
        mul_op.en   = 1'b0;
        mul_op.step = MUL_HL;
      end
      default: begin
        mul_op.en   = 1'b0;
        mul_op.step = MUL_LL;
      end
    endcase
  end

  assign wb_go = (state_q == S_MUL2) && slot_free;

  // The write port serves seed loads at accept time and product write-back.
  always_comb begin
    if (state_q == S_MUL2) begin
      wr_en   = wb_go;
      wr_addr = p_q;
      wr_data = product;
    end else begin
      wr_en   = load_acc;
      wr_addr = PtrW'(load_index_i);
      wr_data = load_value_i | WordW'(1);
    end
  end

  mlf_ring #(
    .Depth(MAX_LAG)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (gen_acc),
    .rd_addr_a_i(ptr_eff),
    .rd_addr_b_i(q_addr),
    .rd_data_a_o(rd_a),
    .rd_data_b_o(rd_b),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clearing_o (clearing)
  );

  mlf_mul u_mul (
    .clk_i   (clk_i),
    .op_i    (mul_op),
    .a_i     (rd_a),
    .b_i     (rd_b),
    .result_o(product)
  );

  // Sequencer, configuration, pointer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      short_lag_q    <= ShortLagRst;
      long_lag_q     <= LongLagRst;
      ptr_q          <= '0;
      out_valid_q    <= 1'b0;
      random_value_q <= '0;
      lag_error_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SHORT_LAG: short_lag_q <= cfg_data_i[ShortLagW-1:0];
          CFG_LONG_LAG:  long_lag_q  <= cfg_data_i;
          default:       ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (gen_acc) begin
            state_q <= lags_ok ? S_MUL0 : S_ERR;
          end
        end
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: begin
          if (slot_free) begin
            out_valid_q    <= 1'b1;
            random_value_q <= product;
            lag_error_q    <= 1'b0;
            ptr_q          <= nxt_ptr_q;
            state_q        <= S_IDLE;
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_valid_q    <= 1'b1;
            random_value_q <= '0;
            lag_error_q    <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_acc) begin
      p_q       <= ptr_eff;
      nxt_ptr_q <= nxt_ptr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = random_value_q;
  assign lag_error_o    = lag_error_q;

endmodule
